>>> src/button_gesture_detector_top_defines.svh
// assertion macros for the button gesture detector
// used by modules that carry concurrent checks; no other dependencies
`ifndef BUTTON_GESTURE_DETECTOR_TOP_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bgd assertion failed");
`define BGD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bgd assertion failed");
`else
`define BGD_ASSERT(lbl, clk, rstn, prop)
`define BGD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/bgd_pkg.sv
// shared types and constants for the button gesture detector
// no dependencies
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 1'b1;

  localparam logic [TICK_W-1:0] LONG_PRESS_RESET   = 32'd1000;
  localparam logic [TICK_W-1:0] DOUBLE_CLICK_RESET = 32'd400;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_HELD    = 2'd2,
    ST_PENDING = 2'd3
  } state_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_SHORT        = 3'd2,
    EV_DOUBLE       = 3'd3,
    EV_LONG         = 3'd4,
    EV_LONG_RELEASE = 3'd5
  } event_t;

  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] dbl_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TICK_W-1:0] tick;
  } step_t;

  typedef struct packed {
    event_t evt;
    state_t state;
  } result_t;

endpackage

>>> src/bgd_cfg_regs.sv
// configuration registers for the two time windows
// depends on bgd_pkg
`timescale 1ns / 1ps

module bgd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::TICK_W-1:0]    cfg_data,
  output logic                          cfg_ready,
  output bgd_pkg::cfg_t                 cfg
);

  bgd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks <= bgd_pkg::LONG_PRESS_RESET;
      cfg_r.dbl_ticks  <= bgd_pkg::DOUBLE_CLICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgd_pkg::CFG_LONG_PRESS:   cfg_r.long_ticks <= cfg_data;
        bgd_pkg::CFG_DOUBLE_CLICK: cfg_r.dbl_ticks  <= cfg_data;
      endcase
    end
  end

endmodule

>>> src/bgd_in_reg.sv
// input register stage holding one accepted word
// depends on bgd_pkg
`timescale 1ns / 1ps

module bgd_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       in_valid,
  input  logic [bgd_pkg::OP_W-1:0]   in_operation,
  input  logic [bgd_pkg::TICK_W-1:0] in_tick,
  output logic                       valid,
  output bgd_pkg::step_t             step
);

  logic           valid_r;
  bgd_pkg::step_t step_r;

  assign valid = valid_r;
  assign step  = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      step_r.op   <= in_operation;
      step_r.tick <= in_tick;
    end
  end

endmodule

>>> src/bgd_fsm.sv
// gesture state machine with press and release time stamps
// depends on bgd_pkg and button_gesture_detector_top_defines.svh
`timescale 1ns / 1ps
`include "button_gesture_detector_top_defines.svh"

module bgd_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_valid,
  input  bgd_pkg::step_t   step,
  input  bgd_pkg::cfg_t    cfg,
  output bgd_pkg::result_t result
);

  bgd_pkg::state_t             state_r, state_nxt;
  logic [bgd_pkg::TICK_W-1:0]  press_time_r, press_time_nxt;
  logic [bgd_pkg::TICK_W-1:0]  release_time_r, release_time_nxt;
  logic                        long_done_r, long_done_nxt;
  logic                        held_down_r, held_down_nxt;
  bgd_pkg::event_t             evt;
  logic [bgd_pkg::TICK_W-1:0]  press_age;
  logic [bgd_pkg::TICK_W-1:0]  release_age;

  assign press_age   = step.tick - press_time_r;
  assign release_age = step.tick - release_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bgd_pkg::ST_IDLE;
      press_time_r   <= '0;
      release_time_r <= '0;
      long_done_r    <= 1'b0;
      held_down_r    <= 1'b0;
    end else if (step_valid) begin
      state_r        <= state_nxt;
      press_time_r   <= press_time_nxt;
      release_time_r <= release_time_nxt;
      long_done_r    <= long_done_nxt;
      held_down_r    <= held_down_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    press_time_nxt   = press_time_r;
    release_time_nxt = release_time_r;
    long_done_nxt    = long_done_r;
    held_down_nxt    = held_down_r;
    evt              = bgd_pkg::EV_NONE;
    unique case (step.op)
      bgd_pkg::OP_PRESS: begin
        if (!held_down_r) begin
          held_down_nxt  = 1'b1;
          press_time_nxt = step.tick;
          long_done_nxt  = 1'b0;
          state_nxt      = bgd_pkg::ST_PRESSED;
          evt            = bgd_pkg::EV_PRESS;
        end
      end
      bgd_pkg::OP_RELEASE: begin
        if (held_down_r) begin
          held_down_nxt = 1'b0;
          if (state_r == bgd_pkg::ST_HELD) begin
            state_nxt        = bgd_pkg::ST_IDLE;
            release_time_nxt = step.tick;
            evt              = bgd_pkg::EV_LONG_RELEASE;
          end else if (state_r == bgd_pkg::ST_PRESSED && release_time_r != '0 &&
                       release_age < cfg.dbl_ticks) begin
            state_nxt        = bgd_pkg::ST_IDLE;
            release_time_nxt = '0;
            evt              = bgd_pkg::EV_DOUBLE;
          end else begin
            state_nxt        = bgd_pkg::ST_PENDING;
            release_time_nxt = step.tick;
          end
        end
      end
      bgd_pkg::OP_UPDATE: begin
        if (held_down_r && state_r == bgd_pkg::ST_PRESSED && !long_done_r &&
            press_age >= cfg.long_ticks) begin
          state_nxt     = bgd_pkg::ST_HELD;
          long_done_nxt = 1'b1;
          evt           = bgd_pkg::EV_LONG;
        end else if (!held_down_r && state_r == bgd_pkg::ST_PENDING &&
                     release_age >= cfg.dbl_ticks) begin
          state_nxt        = bgd_pkg::ST_IDLE;
          release_time_nxt = '0;
          evt              = bgd_pkg::EV_SHORT;
        end
      end
      default: begin
        evt = bgd_pkg::EV_NONE;
      end
    endcase
  end

  assign result.evt   = evt;
  assign result.state = state_nxt;

  // button down exactly in the pressed and held states
  `BGD_ASSERT(a_held_matches_state, clk, rst_n, held_down_r == (state_r == bgd_pkg::ST_PRESSED || state_r == bgd_pkg::ST_HELD))
  `BGD_ASSERT(a_hold_without_step, clk, rst_n, !step_valid |=> $stable(state_r) && $stable(release_time_r))
  `BGD_ASSERT(a_double_clears, clk, rst_n, step_valid && evt == bgd_pkg::EV_DOUBLE |=> state_r == bgd_pkg::ST_IDLE && release_time_r == '0)
  `BGD_ASSERT(a_long_once, clk, rst_n, step_valid && evt == bgd_pkg::EV_LONG |=> long_done_r && state_r == bgd_pkg::ST_HELD)

endmodule

>>> src/bgd_out_reg.sv
// result register stage holding one word for the output channel
// depends on bgd_pkg
`timescale 1ns / 1ps

module bgd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             res_valid,
  input  bgd_pkg::result_t result,
  output logic             out_valid,
  output logic [2:0]       out_event_code,
  output logic [1:0]       out_machine_state
);

  logic             valid_r;
  bgd_pkg::result_t result_r;

  assign out_valid         = valid_r;
  assign out_event_code    = result_r.evt;
  assign out_machine_state = result_r.state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      result_r <= result;
    end
  end

endmodule

>>> src/button_gesture_detector_top.sv
// button gesture detector: input register, gesture state machine, result register
// depends on bgd_pkg, bgd_cfg_regs, bgd_in_reg, bgd_fsm, bgd_out_reg
// path: input register, then result register; result held there while out_stall is high
// throughput: one word per cycle unless out_stall holds, set by the single state machine pass
// reset: synchronous active-low; state idle, time stamps zero, windows 1000 and 400 ticks
// no clearing pass, a word can be accepted as soon as reset is released
`timescale 1ns / 1ps

module button_gesture_detector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bgd_pkg::OP_W-1:0]      in_operation,
  input  logic [bgd_pkg::TICK_W-1:0]    in_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_event_code,
  output logic [1:0]                    out_machine_state,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::TICK_W-1:0]    cfg_data
);

  bgd_pkg::cfg_t    cfg;
  bgd_pkg::step_t   step;
  bgd_pkg::result_t result;
  logic             step_valid_q;
  logic             out_load;
  logic             in_load;
  logic             step_fire;

  assign out_load  = !out_valid || !out_stall;
  assign step_fire = step_valid_q && out_load;
  assign in_load   = !step_valid_q || out_load;
  assign in_stall  = !in_load;

  bgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  bgd_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_load),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_tick      (in_tick),
    .valid        (step_valid_q),
    .step         (step)
  );

  bgd_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_fire),
    .step       (step),
    .cfg        (cfg),
    .result     (result)
  );

  bgd_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (out_load),
    .res_valid         (step_fire),
    .result            (result),
    .out_valid         (out_valid),
    .out_event_code    (out_event_code),
    .out_machine_state (out_machine_state)
  );

endmodule
